// ----- rtl/core/sft_pkg.sv -----
package sft_pkg;

  localparam int SigW      = 32;
  localparam int WideW     = 64;
  localparam int DivNW     = 80;
  localparam int ShW       = 6;

  localparam logic [31:0] TS_RESET = 32'd1590728;
  localparam logic [30:0] W0_RESET = 31'd20588835;
  localparam logic [30:0] K_RESET  = 31'd92682;
  localparam logic [30:0] KI_RESET = 31'd655360000;

  localparam logic [1:0] REG_TS = 2'd0;
  localparam logic [1:0] REG_W0 = 2'd1;
  localparam logic [1:0] REG_K  = 2'd2;
  localparam logic [1:0] REG_KI = 2'd3;

  localparam logic signed [31:0] CORR_MAX = 32'sd1966080;
  localparam logic [63:0] PEAK_MIN  = 64'd66;
  localparam logic [63:0] PEAK_MAX  = 64'h7FFF_FFFF;
  localparam logic [63:0] X_MAX     = 64'd536870911;
  localparam logic [63:0] Q24_ONE   = 64'd16777216;
  localparam logic [63:0] C0_MAX    = 64'd1073741823;
  localparam logic [63:0] ERR_SAT   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LIM_NUM   = 64'h0040_0000_0000_0000;
  localparam logic [63:0] STEP_SAT  = 64'h0000_0000_0040_0000;

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // round half up, then floor shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/sogi_fll_quadrature_tracker.sv -----
// SOGI-FLL single-phase tracker. Each input beat is one Q16.16 voltage sample;
// each output beat carries alpha, beta, the updated frequency estimate and the
// floored peak. A finished sample waits, if need be, for the result register to
// drain. A small sequencer walks the filter and loop arithmetic through a shift-add
// multiplier (15 or 16 products), a restoring divider (four or five divisions), a
// square root and a normalizing shift.
// in_tready is high only while the sequencer is idle.
// Configuration writes are always taken and must arrive while no sample is in work.
module sogi_fll_quadrature_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] sample
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] in_phase, [63:32] quadrature,
                                   // [94:64] freq_estimate, [125:95] amplitude
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import sft_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_XQ, ST_X2, ST_KX, ST_NORM, ST_C0, ST_C1, ST_C2,
    ST_A0, ST_A1, ST_A2, ST_U, ST_B0, ST_B1, ST_B2, ST_SA, ST_SB,
    ST_SQRT, ST_PK2, ST_MAG, ST_ERRF, ST_KT, ST_LIM, ST_DELTA, ST_DONE
  } state_t;

  state_t state_r;
  logic   go_r;

  logic [31:0] ts_r;
  logic [30:0] w0_r, k_r, ki_r;

  logic signed [31:0] s_r, sd1_r, sd2_r, ad1_r, ad2_r, bd1_r, bd2_r;
  logic signed [31:0] corr_r, alpha_r, beta_r;
  logic [63:0] w_r, xq_r, x2_r, kx_r, d_r, sumsq_r, pk2_r, tmp_r, errf_r, kt_r, delta_r;
  logic [30:0] peak_r;
  logic signed [63:0] c0_r, c1_r, c2_r, acc_r, u_r;
  logic [ShW-1:0] sh_r;
  logic neg_r;

  logic        mul_start, div_start, sqrt_start;
  logic [63:0] mul_a, mul_b, mul_p, div_d;
  logic [DivNW-1:0] div_n, div_q;
  logic [31:0] sqrt_r;
  logic        mul_done, div_done, sqrt_done, unit_done;

  logic [31:0] out_alpha_r, out_beta_r;
  logic [30:0] out_freq_r, out_peak_r;
  logic        out_valid_r;

  sft_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .p(mul_p));
  sft_div u_div (.clk, .rst_n, .start(div_start), .n(div_n), .d(div_d),
                 .done(div_done), .q(div_q));
  sft_sqrt u_sqrt (.clk, .rst_n, .start(sqrt_start), .v(sumsq_r),
                   .done(sqrt_done), .r(sqrt_r));

  assign unit_done = mul_done | div_done | sqrt_done;

  function automatic logic [63:0] estimate(input logic [30:0] w0, input logic signed [31:0] c);
    logic signed [33:0] w;
    logic [63:0] r;
    w = $signed({3'b000, w0}) + {{2{c[31]}}, c};
    if (w < 34'sd0) r = '0;
    else if (w > 34'sd2147483647) r = 64'h7FFF_FFFF;
    else r = {30'd0, w};
    return r;
  endfunction

  // numerator magnitudes and signs of the c1 and c2 coefficients
  logic signed [63:0] n1, n2;
  logic [63:0] m1, m2, dsh, e_abs, b_abs;
  logic signed [63:0] e_val;
  logic [63:0] q64;

  assign n1    = $signed(x2_r) - $signed(Q24_ONE);
  assign n2    = $signed(x2_r) + $signed(Q24_ONE) - $signed(kx_r);
  assign m1    = (n1[63] ? 64'(-n1) : n1) >> sh_r;
  assign m2    = (n2[63] ? 64'(-n2) : n2) >> sh_r;
  assign dsh   = d_r >> sh_r;
  assign e_val = sx32(s_r) - sx32(alpha_r);
  assign e_abs = e_val[63] ? 64'(-e_val) : e_val;
  assign b_abs = beta_r[31] ? 64'(-sx32(beta_r)) : sx32(beta_r);
  assign q64   = div_q[63:0];

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_n      = '0;
    div_d      = dsh;
    unique case (state_r)
      ST_XQ:    begin mul_a = {32'd0, ts_r}; mul_b = w_r; end
      ST_X2:    begin mul_a = xq_r; mul_b = xq_r; end
      ST_KX:    begin mul_a = {33'd0, k_r}; mul_b = xq_r; end
      ST_C0:    div_n = DivNW'((kx_r >> sh_r) << 30);
      ST_C1:    div_n = DivNW'(m1 << 30);
      ST_C2:    div_n = DivNW'(m2 << 30);
      ST_A0:    begin mul_a = c0_r; mul_b = sx32(s_r) - sx32(sd2_r); end
      ST_A1:    begin mul_a = c1_r; mul_b = sx32(ad1_r); end
      ST_A2:    begin mul_a = c2_r; mul_b = sx32(ad2_r); end
      ST_U:     begin
        mul_a = c0_r;
        mul_b = sx32(s_r) + (sx32(sd1_r) <<< 1) + sx32(sd2_r);
      end
      ST_B0:    begin mul_a = u_r; mul_b = xq_r; end
      ST_B1:    begin mul_a = c1_r; mul_b = sx32(bd1_r); end
      ST_B2:    begin mul_a = c2_r; mul_b = sx32(bd2_r); end
      ST_SA:    begin mul_a = sx32(alpha_r); mul_b = sx32(alpha_r); end
      ST_SB:    begin mul_a = sx32(beta_r); mul_b = sx32(beta_r); end
      ST_PK2:   begin mul_a = {33'd0, peak_r}; mul_b = {33'd0, peak_r}; end
      ST_MAG:   begin mul_a = e_abs; mul_b = b_abs; end
      ST_ERRF:  begin div_n = {tmp_r, 16'd0}; div_d = pk2_r; end
      ST_KT:    begin mul_a = {33'd0, ki_r}; mul_b = {32'd0, ts_r}; end
      ST_LIM:   begin div_n = {16'd0, LIM_NUM}; div_d = kt_r; end
      ST_DELTA: begin mul_a = errf_r; mul_b = kt_r; end
      default:  ;
    endcase
    if (!go_r) begin
      unique case (state_r)
        ST_C0, ST_C1, ST_C2, ST_ERRF, ST_LIM: div_start = 1'b1;
        ST_SQRT: sqrt_start = 1'b1;
        ST_IDLE, ST_NORM, ST_DONE: ;
        default: mul_start = 1'b1;
      endcase
    end
  end

  logic signed [31:0] corr_nxt;
  logic signed [63:0] corr_sum;
  logic [63:0]        w_next;
  assign corr_sum = sx32(corr_r) + (neg_r ? $signed(delta_r) : -$signed(delta_r));
  assign corr_nxt = (corr_sum > sx32(CORR_MAX)) ? CORR_MAX :
                    (corr_sum < -sx32(CORR_MAX)) ? -CORR_MAX : corr_sum[31:0];
  assign w_next   = estimate(w0_r, corr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      ts_r        <= TS_RESET;
      w0_r        <= W0_RESET;
      k_r         <= K_RESET;
      ki_r        <= KI_RESET;
      sd1_r <= '0; sd2_r <= '0; ad1_r <= '0; ad2_r <= '0;
      bd1_r <= '0; bd2_r <= '0; corr_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TS: ts_r <= cfg_data;
          REG_W0: w0_r <= cfg_data[30:0];
          REG_K:  k_r  <= cfg_data[30:0];
          REG_KI: ki_r <= cfg_data[30:0];
        endcase
      end
      // the done state reloads the result register itself
      if (out_valid_r && out_tready && state_r != ST_DONE) out_valid_r <= 1'b0;

      if (mul_start || div_start || sqrt_start) go_r <= 1'b1;

      unique case (state_r)
        ST_IDLE: if (in_tvalid) begin
          s_r     <= in_tdata;
          w_r     <= estimate(w0_r, corr_r);
          sh_r    <= '0;
          state_r <= ST_XQ;
        end
        ST_NORM: begin
          if ((d_r >> sh_r) >= 64'h1_0000_0000) sh_r <= sh_r + 1'b1;
          else state_r <= ST_C0;
        end
        ST_DONE: if (!out_valid_r || out_tready) begin
          corr_r      <= corr_nxt;
          sd2_r <= sd1_r; sd1_r <= s_r;
          ad2_r <= ad1_r; ad1_r <= alpha_r;
          bd2_r <= bd1_r; bd1_r <= beta_r;
          out_alpha_r <= alpha_r;
          out_beta_r  <= beta_r;
          out_freq_r  <= w_next[30:0];
          out_peak_r  <= peak_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: if (go_r && unit_done) begin
          go_r <= 1'b0;
          unique case (state_r)
            ST_XQ:  begin
              xq_r    <= ((mul_p >> 25) > X_MAX) ? X_MAX : (mul_p >> 25);
              state_r <= ST_X2;
            end
            ST_X2:  begin x2_r <= mul_p >> 24; state_r <= ST_KX; end
            ST_KX:  begin
              kx_r    <= mul_p >> 16;
              d_r     <= x2_r + (mul_p >> 16) + Q24_ONE;
              state_r <= ST_NORM;
            end
            ST_C0:  begin c0_r <= (q64 > C0_MAX) ? C0_MAX : q64; state_r <= ST_C1; end
            ST_C1:  begin
              c1_r    <= (n1[63] ? -$signed(q64) : $signed(q64)) <<< 1;
              state_r <= ST_C2;
            end
            ST_C2:  begin
              c2_r    <= n2[63] ? -$signed(q64) : $signed(q64);
              state_r <= ST_A0;
            end
            ST_A0:  begin acc_r <= rnd(mul_p, 30); state_r <= ST_A1; end
            ST_A1:  begin acc_r <= acc_r - rnd(mul_p, 30); state_r <= ST_A2; end
            ST_A2:  begin alpha_r <= sat32(acc_r - rnd(mul_p, 30)); state_r <= ST_U; end
            ST_U:   begin u_r <= rnd(mul_p, 30); state_r <= ST_B0; end
            ST_B0:  begin acc_r <= rnd(mul_p, 24); state_r <= ST_B1; end
            ST_B1:  begin acc_r <= acc_r - rnd(mul_p, 30); state_r <= ST_B2; end
            ST_B2:  begin beta_r <= sat32(acc_r - rnd(mul_p, 30)); state_r <= ST_SA; end
            ST_SA:  begin sumsq_r <= mul_p; state_r <= ST_SB; end
            ST_SB:  begin sumsq_r <= sumsq_r + mul_p; state_r <= ST_SQRT; end
            ST_SQRT: begin
              if ({32'd0, sqrt_r} > PEAK_MAX) peak_r <= 31'h7FFF_FFFF;
              else if ({32'd0, sqrt_r} <= PEAK_MIN) peak_r <= 31'(PEAK_MIN);
              else peak_r <= sqrt_r[30:0];
              state_r <= ST_PK2;
            end
            ST_PK2: begin pk2_r <= mul_p; state_r <= ST_MAG; end
            ST_MAG: begin
              tmp_r   <= mul_p;
              neg_r   <= e_val[63] != beta_r[31];
              state_r <= ST_ERRF;
            end
            ST_ERRF: begin
              errf_r  <= (div_q >= {16'd0, ERR_SAT}) ? ERR_SAT : q64;
              state_r <= ST_KT;
            end
            ST_KT:  begin
              kt_r <= mul_p >> 16;
              if ((mul_p >> 16) == '0 || errf_r == '0) begin
                delta_r <= '0;
                state_r <= ST_DONE;
              end else begin
                state_r <= ST_LIM;
              end
            end
            ST_LIM: begin
              if (errf_r > q64) begin
                delta_r <= STEP_SAT;
                state_r <= ST_DONE;
              end else begin
                state_r <= ST_DELTA;
              end
            end
            ST_DELTA: begin delta_r <= mul_p >> 32; state_r <= ST_DONE; end
            default: state_r <= ST_IDLE;
          endcase
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_peak_r, out_freq_r, out_beta_r, out_alpha_r};

  a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_done, div_done, sqrt_done})) else $error("two units done at once");
  a_idle_no_launch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !go_r) else $error("unit pending while idle");
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (corr_r <= CORR_MAX) && (corr_r >= -CORR_MAX)) else $error("correction out of range");
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_C0 |-> dsh < 64'h1_0000_0000) else $error("divisor not normalized");
endmodule

// ----- rtl/core/sft_mul.sv -----
module sft_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  import sft_pkg::*;

  logic [63:0] a_r, b_r, p_r;
  logic        run_r, done_r;

  // shift-add, low 64 bits; stops once the multiplier runs out of ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        p_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (b_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) p_r <= p_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

// ----- rtl/core/sft_div.sv -----
module sft_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sft_pkg::DivNW-1:0] n,
  input  logic [63:0]              d,
  output logic                     done,
  output logic [sft_pkg::DivNW-1:0] q
);
  import sft_pkg::*;

  localparam int CntW = $clog2(DivNW);

  logic [DivNW-1:0] quo_r;
  logic [63:0]      rem_r, d_r;
  logic [CntW-1:0]  cnt_r;
  logic             run_r, done_r;
  logic [64:0]      trial;

  assign trial = {rem_r, quo_r[DivNW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= n;
        rem_r <= '0;
        d_r   <= d;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= 64'(trial - {1'b0, d_r});
          quo_r <= {quo_r[DivNW-2:0], 1'b1};
        end else begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[DivNW-2:0], 1'b0};
        end
        if (cnt_r == CntW'(DivNW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign q    = quo_r;
endmodule

// ----- rtl/core/sft_sqrt.sv -----
module sft_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] r
);
  import sft_pkg::*;

  logic [63:0] v_r, r_r, bit_r;
  logic        run_r, done_r;
  logic [63:0] sum;

  assign sum = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= v;
        r_r   <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (bit_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (v_r >= sum) begin
            v_r <= v_r - sum;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
    end
  end

  assign done = done_r;
  assign r    = r_r[31:0];
endmodule
